// ----- src/hpid_pkg.sv -----
package hpid_pkg;

	// Field widths.
	localparam int HeadingW = 20;
	localparam int ErrW     = HeadingW + 1;
	localparam int IntW     = 32;
	localparam int GainW    = 16;
	localparam int DriveW   = 8;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 20;

	// Product and sum widths of the drive path.
	localparam int ProdPW = ErrW + GainW + 1;
	localparam int ProdDW = ErrW + 1 + GainW + 1;
	localparam int ProdIW = IntW + GainW + 1;
	localparam int SumW   = ProdIW + 2;
	localparam int TermW  = SumW + 4;

	// The scaled sum is divided by 4096 with a shift and then by 10 with a reciprocal.
	localparam int FracShift = 12;
	localparam int Q1W       = 11;
	localparam int RecipW    = 13;
	localparam int RecipSh   = 16;
	localparam logic [Q1W-1:0]    Q1Limit  = 11'd1280;
	localparam logic [RecipW-1:0] Recip10  = 13'd6554;
	localparam logic [6:0]        DriveMax = 7'd127;

	// Integral saturation bounds.
	localparam logic signed [IntW-1:0] IntMax = {1'b0, {(IntW-1){1'b1}}};
	localparam logic signed [IntW-1:0] IntMin = {1'b1, {(IntW-1){1'b0}}};

	// Register reset values.
	localparam logic [HeadingW-1:0] TargetRst = 20'd0;
	localparam logic [GainW-1:0]    ThreshRst = 16'd16;
	localparam logic [GainW-1:0]    GainPRst  = 16'd320;
	localparam logic [GainW-1:0]    GainIRst  = 16'd230;
	localparam logic [GainW-1:0]    GainDRst  = 16'd200;
	localparam logic [GainW-1:0]    WindowRst = 16'd320;

	// Configuration register indexes.
	typedef enum logic [CfgIdxW-1:0] {
		CFG_TARGET = 3'd0,
		CFG_THRESH = 3'd1,
		CFG_GAIN_P = 3'd2,
		CFG_GAIN_I = 3'd3,
		CFG_GAIN_D = 3'd4,
		CFG_WINDOW = 3'd5
	} cfg_idx_t;

	// Controller state handed from the error stage to the drive path.
	typedef struct packed {
		logic                   done;
		logic signed [ErrW-1:0] err_cur;
		logic signed [ErrW-1:0] err_prev;
		logic signed [IntW-1:0] integ;
	} err_state_t;

endpackage

// ----- src/heading_pid_turn_controller_top.sv -----
// Heading PID turn controller. Each request (func, heading) yields one result
// (drive, done_res): func 1 starts a turn, func 0 updates with a new sample. The block
// takes one request per clock unless the pipeline holds; the error and integral state
// is closed in the error stage, and the gain multiplies, the term sum, the scaling by
// nine and the divide by 40960 follow in pipeline stages. When the result is not
// taken, the whole pipeline holds. Configuration writes are always
// accepted; write them only while no request is in flight.
module heading_pid_turn_controller_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  func,
	input  logic signed [hpid_pkg::HeadingW-1:0]  heading,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [hpid_pkg::DriveW-1:0]    drive,
	output logic                                  done_res,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic        [hpid_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic        [hpid_pkg::CfgDataW-1:0]  cfg_data
);

	// Configuration registers.
	logic signed [hpid_pkg::HeadingW-1:0] target_q;
	logic        [hpid_pkg::GainW-1:0]    thresh_q;
	logic        [hpid_pkg::GainW-1:0]    gain_p_q;
	logic        [hpid_pkg::GainW-1:0]    gain_i_q;
	logic        [hpid_pkg::GainW-1:0]    gain_d_q;
	logic        [hpid_pkg::GainW-1:0]    window_q;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic out_valid_q;

	logic                                 func_s1;
	logic signed [hpid_pkg::HeadingW-1:0] heading_s1;
	hpid_pkg::err_state_t                 st;

	logic signed [hpid_pkg::ErrW-1:0]   e_cur;
	logic signed [hpid_pkg::ErrW-1:0]   e_prev;
	logic signed [hpid_pkg::IntW-1:0]   e_int;
	logic signed [hpid_pkg::ErrW:0]     e_diff;
	logic signed [hpid_pkg::ProdPW-1:0] prod_p_d, prod_p_s3;
	logic signed [hpid_pkg::ProdDW-1:0] prod_d_d, prod_d_s3;
	logic signed [hpid_pkg::ProdIW-1:0] prod_i_d, prod_i_s3;
	logic                               done_s3;

	logic signed [hpid_pkg::SumW-1:0]  sum_d, sum_s4;
	logic                              done_s4;

	logic signed [hpid_pkg::TermW-1:0] sum_x;
	logic signed [hpid_pkg::TermW-1:0] t_d, t_s5;
	logic                              done_s5;

	logic [hpid_pkg::TermW-1:0]                    mag_d;
	logic [hpid_pkg::TermW-hpid_pkg::FracShift-1:0] q1_full;
	logic                                          big_d, big_s6;
	logic [hpid_pkg::Q1W-1:0]                      q1_s6;
	logic                                          neg_s6;
	logic                                          done_s6;

	logic [hpid_pkg::Q1W+hpid_pkg::RecipW-1:0] q_prod;
	logic [6:0]                                q_mag;
	logic signed [hpid_pkg::DriveW-1:0]        drive_d, drive_q;
	logic                                      done_q;

	// Configuration writes.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= hpid_pkg::TargetRst;
			thresh_q <= hpid_pkg::ThreshRst;
			gain_p_q <= hpid_pkg::GainPRst;
			gain_i_q <= hpid_pkg::GainIRst;
			gain_d_q <= hpid_pkg::GainDRst;
			window_q <= hpid_pkg::WindowRst;
		end else if (cfg_valid) begin
			case (cfg_index)
				hpid_pkg::CFG_TARGET: target_q <= cfg_data;
				hpid_pkg::CFG_THRESH: thresh_q <= cfg_data[hpid_pkg::GainW-1:0];
				hpid_pkg::CFG_GAIN_P: gain_p_q <= cfg_data[hpid_pkg::GainW-1:0];
				hpid_pkg::CFG_GAIN_I: gain_i_q <= cfg_data[hpid_pkg::GainW-1:0];
				hpid_pkg::CFG_GAIN_D: gain_d_q <= cfg_data[hpid_pkg::GainW-1:0];
				hpid_pkg::CFG_WINDOW: window_q <= cfg_data[hpid_pkg::GainW-1:0];
				default: ;
			endcase
		end
	end

	// The pipeline advances whenever the result register is free or being taken.
	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= in_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			v_s6        <= v_s5;
			out_valid_q <= v_s6;
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (en) begin
			func_s1    <= func;
			heading_s1 <= heading;
		end
	end

	// Error and integral update.
	hpid_integrator u_integ (
		.clk     (clk),
		.arst_n  (arst_n),
		.upd     (en && v_s1),
		.start   (func_s1),
		.heading (heading_s1),
		.target  (target_q),
		.window  (window_q),
		.thresh  (thresh_q),
		.st      (st)
	);

	// Gain products.
	assign e_cur    = st.err_cur;
	assign e_prev   = st.err_prev;
	assign e_int    = st.integ;
	assign e_diff   = {e_cur[hpid_pkg::ErrW-1], e_cur} - {e_prev[hpid_pkg::ErrW-1], e_prev};
	assign prod_p_d = $signed({1'b0, gain_p_q}) * e_cur;
	assign prod_d_d = $signed({1'b0, gain_d_q}) * e_diff;
	assign prod_i_d = $signed({1'b0, gain_i_q}) * e_int;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_p_s3 <= prod_p_d;
			prod_d_s3 <= prod_d_d;
			prod_i_s3 <= prod_i_d;
			done_s3   <= st.done;
		end
	end

	// Term sum.
	assign sum_d = prod_p_s3 + prod_d_s3 + prod_i_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s4  <= sum_d;
			done_s4 <= done_s3;
		end
	end

	// Times nine as a shift and add.
	assign sum_x = sum_s4;
	assign t_d   = sum_x + (sum_x <<< 3);

	always_ff @(posedge clk) begin
		if (en) begin
			t_s5    <= t_d;
			done_s5 <= done_s4;
		end
	end

	// Magnitude divided by 4096; quotients of 1280 or more (a final 128 or more) saturate.
	assign mag_d   = t_s5[hpid_pkg::TermW-1] ? -t_s5 : t_s5;
	assign q1_full = mag_d[hpid_pkg::TermW-1:hpid_pkg::FracShift];
	assign big_d   = (|q1_full[hpid_pkg::TermW-hpid_pkg::FracShift-1:hpid_pkg::Q1W]) ||
	                 (q1_full[hpid_pkg::Q1W-1:0] >= hpid_pkg::Q1Limit);

	always_ff @(posedge clk) begin
		if (en) begin
			q1_s6   <= q1_full[hpid_pkg::Q1W-1:0];
			big_s6  <= big_d;
			neg_s6  <= t_s5[hpid_pkg::TermW-1];
			done_s6 <= done_s5;
		end
	end

	// Divide by ten with a reciprocal multiply, then restore the sign.
	assign q_prod = q1_s6 * hpid_pkg::Recip10;
	assign q_mag  = big_s6 ? hpid_pkg::DriveMax
	                       : q_prod[hpid_pkg::RecipSh+6:hpid_pkg::RecipSh];
	always_comb begin
		if (done_s6) begin
			drive_d = '0;
		end else if (neg_s6) begin
			drive_d = -$signed({1'b0, q_mag});
		end else begin
			drive_d = $signed({1'b0, q_mag});
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (en) begin
			drive_q <= drive_d;
			done_q  <= done_s6;
		end
	end

	assign out_valid = out_valid_q;
	assign drive     = drive_q;
	assign done_res  = done_q;

`ifndef SYNTHESIS
	// A finished turn never drives the motor.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> drive == '0)
		else $error("drive is not zero on a done result");

	// The drive stays within the symmetric limit.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> drive != {1'b1, {(hpid_pkg::DriveW-1){1'b0}}})
		else $error("drive reached the most negative code");

	// A result appears only from the last pipeline stage or is held from before.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $past(v_s6) || $past(out_valid))
		else $error("result appeared without a request in the last stage");
`endif

endmodule

// ----- src/hpid_integrator.sv -----
module hpid_integrator (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   upd,
	input  logic                                   start,
	input  logic signed [hpid_pkg::HeadingW-1:0]   heading,
	input  logic signed [hpid_pkg::HeadingW-1:0]   target,
	input  logic        [hpid_pkg::GainW-1:0]      window,
	input  logic        [hpid_pkg::GainW-1:0]      thresh,
	output hpid_pkg::err_state_t                   st
);

	logic signed [hpid_pkg::ErrW-1:0] cur_q;
	logic signed [hpid_pkg::ErrW-1:0] prev_q;
	logic signed [hpid_pkg::IntW-1:0] integ_q;
	logic                             done_q;

	logic signed [hpid_pkg::ErrW-1:0] err_w;
	logic        [hpid_pkg::ErrW-1:0] err_mag;
	logic signed [hpid_pkg::ErrW-1:0] prev_new;
	logic        [hpid_pkg::ErrW-1:0] prev_mag;
	logic                             in_win;
	logic                             flip;
	logic signed [hpid_pkg::IntW:0]   sum_w;
	logic signed [hpid_pkg::IntW-1:0] sum_sat;
	logic signed [hpid_pkg::IntW-1:0] int_add;
	logic signed [hpid_pkg::IntW+1:0] x_ext;
	logic signed [hpid_pkg::IntW+1:0] neg3x;
	logic signed [hpid_pkg::IntW+1:0] neg3x_rnd;
	logic signed [hpid_pkg::IntW+1:0] scaled_w;
	logic signed [hpid_pkg::IntW-1:0] scaled_sat;
	logic signed [hpid_pkg::IntW-1:0] int_upd;
	logic                             done_d;

	// New error and its magnitude; the most negative value reads correctly as unsigned.
	assign err_w   = {target[hpid_pkg::HeadingW-1], target} -
	                 {heading[hpid_pkg::HeadingW-1], heading};
	assign err_mag = err_w[hpid_pkg::ErrW-1] ? -err_w : err_w;

	// Conditional integration with saturation at the 32-bit limits.
	assign in_win  = err_mag < {{(hpid_pkg::ErrW-hpid_pkg::GainW){1'b0}}, window};
	assign sum_w   = {integ_q[hpid_pkg::IntW-1], integ_q} +
	                 {{(hpid_pkg::IntW+1-hpid_pkg::ErrW){err_w[hpid_pkg::ErrW-1]}}, err_w};
	always_comb begin
		if (sum_w[hpid_pkg::IntW] != sum_w[hpid_pkg::IntW-1]) begin
			sum_sat = sum_w[hpid_pkg::IntW] ? hpid_pkg::IntMin : hpid_pkg::IntMax;
		end else begin
			sum_sat = sum_w[hpid_pkg::IntW-1:0];
		end
	end
	assign int_add = in_win ? sum_sat : integ_q;

	// On a sign change the integral becomes -3/4 of itself, truncated toward zero.
	assign flip      = err_w[hpid_pkg::ErrW-1] != cur_q[hpid_pkg::ErrW-1];
	assign x_ext     = {{2{int_add[hpid_pkg::IntW-1]}}, int_add};
	assign neg3x     = -(x_ext + (x_ext <<< 1));
	assign neg3x_rnd = neg3x + (neg3x[hpid_pkg::IntW+1] ? 34'sd3 : 34'sd0);
	assign scaled_w  = neg3x_rnd >>> 2;

	// Saturate at the 32-bit limits; -3/4 of any 32-bit integral fits, so it never clips.
	always_comb begin
		if ((scaled_w[hpid_pkg::IntW+1:hpid_pkg::IntW-1] == 3'b000) ||
		    (scaled_w[hpid_pkg::IntW+1:hpid_pkg::IntW-1] == 3'b111)) begin
			scaled_sat = scaled_w[hpid_pkg::IntW-1:0];
		end else begin
			scaled_sat = scaled_w[hpid_pkg::IntW+1] ? hpid_pkg::IntMin : hpid_pkg::IntMax;
		end
	end
	assign int_upd   = flip ? scaled_sat : int_add;

	// Both errors inside the completion band.
	assign prev_new = start ? err_w : cur_q;
	assign prev_mag = prev_new[hpid_pkg::ErrW-1] ? -prev_new : prev_new;
	assign done_d   = (err_mag <= {{(hpid_pkg::ErrW-hpid_pkg::GainW){1'b0}}, thresh}) &&
	                  (prev_mag <= {{(hpid_pkg::ErrW-hpid_pkg::GainW){1'b0}}, thresh});

	// Controller state, updated once per accepted request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q   <= '0;
			prev_q  <= '0;
			integ_q <= '0;
			done_q  <= 1'b0;
		end else if (upd) begin
			cur_q   <= err_w;
			prev_q  <= prev_new;
			integ_q <= start ? '0 : int_upd;
			done_q  <= done_d;
		end
	end

	assign st.done     = done_q;
	assign st.err_cur  = cur_q;
	assign st.err_prev = prev_q;
	assign st.integ    = integ_q;

endmodule
